// ===== src/timestamp_reorder_buffer_assert.svh =====
// Assertion macros shared by the reorder buffer modules
`ifndef TIMESTAMP_REORDER_BUFFER_ASSERT_SVH
`define TIMESTAMP_REORDER_BUFFER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define TRB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define TRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/trb_pkg.sv =====
// Shared types, codes and constants of the timestamp reorder buffer
`timescale 1ns / 1ps
package trb_pkg;

  localparam int DEPTH_DEF     = 256;
  localparam int MAX_WIDTH_DEF = 8;

  localparam int TIME_W  = 48;
  localparam int TAG_W   = 40;
  localparam int LAT_W   = 24;
  localparam int IDX_W   = 8;
  localparam int STAT_W  = 2;
  localparam int SLOT_W  = 8;
  localparam int RET_W   = 4;
  localparam int OCC_W   = 9;
  localparam int CNT_W   = 48;
  localparam int RW_W    = 4;
  localparam int CADDR_W = 4;
  localparam int CDATA_W = 24;

  localparam logic [RW_W-1:0]  RETIRE_WIDTH_RST = 4'd4;
  localparam logic [LAT_W-1:0] MEM_DELAY_RST    = 24'd500000;

  localparam logic [CADDR_W-1:0] REG_RETIRE_WIDTH = 4'd0;
  localparam logic [CADDR_W-1:0] REG_MEM_DELAY    = 4'd1;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_ZOMBIE = 2'd2;
  localparam logic [STAT_W-1:0] ST_LOST   = 2'd3;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_INSERT = 2'd1,
    OP_WAKEUP = 2'd2,
    OP_REARM  = 2'd3
  } op_t;

  typedef struct packed {
    logic [TIME_W-1:0] birth;
    logic [TIME_W-1:0] ready;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  typedef struct packed {
    logic load;
    logic now_inc;
    logic ins;
    logic rearm;
    logic set_full;
    logic set_zombie;
    logic wake_rd;
    logic wake_wr;
    logic wake_acc;
    logic head_rd;
    logic take_delta;
    logic retire;
    logic out_load;
  } trb_cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic idx_ok;
    logic can_retire;
    logic head_ready;
    logic tag_match;
    logic out_free;
  } trb_sts_t;

endpackage

// ===== src/trb_ifs.sv =====
// Valid/ready channel interfaces for items, results and register writes
`timescale 1ns / 1ps
interface trb_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  opcode;
  logic [trb_pkg::TAG_W-1:0]   inst_tag;
  logic [trb_pkg::LAT_W-1:0]   latency;
  logic [trb_pkg::IDX_W-1:0]   entry_index;

  modport source (output valid, opcode, inst_tag, latency, entry_index, input ready);
  modport sink   (input valid, opcode, inst_tag, latency, entry_index, output ready);
endinterface

interface trb_out_if;
  logic                        valid;
  logic                        ready;
  logic [trb_pkg::STAT_W-1:0]  status;
  logic [trb_pkg::SLOT_W-1:0]  slot;
  logic [trb_pkg::RET_W-1:0]   retired;
  logic [trb_pkg::OCC_W-1:0]   occupancy;
  logic [trb_pkg::CNT_W-1:0]   wake_count;
  logic [trb_pkg::CNT_W-1:0]   wake_delay_sum;

  modport source (output valid, status, slot, retired, occupancy, wake_count,
                  wake_delay_sum, input ready);
  modport sink   (input valid, status, slot, retired, occupancy, wake_count,
                  wake_delay_sum, output ready);
endinterface

interface trb_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [trb_pkg::CADDR_W-1:0]   addr;
  logic [trb_pkg::CDATA_W-1:0]   data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// ===== src/trb_ctrl.sv =====
// Sequencing state machine of the timestamp reorder buffer
`timescale 1ns / 1ps
`include "timestamp_reorder_buffer_assert.svh"
module trb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  trb_pkg::trb_sts_t sts,
  output trb_pkg::trb_cmd_t cmd
);
  import trb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD,
    S_CHK,
    S_RET,
    S_WCHK,
    S_WACC,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        case (sts.op)
          OP_TICK: begin
            cmd.now_inc = 1'b1;
            state_next  = S_RD;
          end
          OP_INSERT: begin
            if (sts.full) begin
              cmd.set_full = 1'b1;
            end else begin
              cmd.ins = 1'b1;
            end
          end
          OP_WAKEUP: begin
            if (sts.idx_ok) begin
              cmd.wake_rd = 1'b1;
              state_next  = S_WCHK;
            end else begin
              cmd.set_zombie = 1'b1;
            end
          end
          OP_REARM: begin
            cmd.rearm = sts.idx_ok;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_RD: begin
        if (sts.can_retire) begin
          cmd.head_rd = 1'b1;
          state_next  = S_CHK;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CHK: begin
        if (sts.head_ready) begin
          cmd.take_delta = 1'b1;
          state_next     = S_RET;
        end else begin
          state_next = S_DONE;
        end
      end
      S_RET: begin
        cmd.retire = 1'b1;
        state_next = S_RD;
      end
      S_WCHK: begin
        if (sts.tag_match) begin
          cmd.wake_wr = 1'b1;
          state_next  = S_WACC;
        end else begin
          cmd.set_zombie = 1'b1;
          state_next     = S_DONE;
        end
      end
      S_WACC: begin
        cmd.wake_acc = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `TRB_ASSERT_NOW(a_no_result_overwrite, cmd.out_load, sts.out_free, "result register overwritten")
  `TRB_ASSERT_NEXT(a_load_starts_exec, cmd.load, state == S_EXEC && !req_ready, "beat taken while busy")

endmodule

// ===== src/trb_dpath.sv =====
// Entry memory, pointers, clock, statistics and result register
`timescale 1ns / 1ps
`include "timestamp_reorder_buffer_assert.svh"
module trb_dpath #(
  parameter int DEPTH     = trb_pkg::DEPTH_DEF,
  parameter int MAX_WIDTH = trb_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  trb_pkg::trb_cmd_t           cmd,
  output trb_pkg::trb_sts_t           sts,
  input  logic [1:0]                  opcode,
  input  logic [trb_pkg::TAG_W-1:0]   inst_tag,
  input  logic [trb_pkg::LAT_W-1:0]   latency,
  input  logic [trb_pkg::IDX_W-1:0]   entry_index,
  trb_out_if.source                   rsp,
  trb_cfg_if.sink                     cfg
);
  import trb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = $clog2(MAX_WIDTH + 1);
  localparam int XW = (CW > IDX_W) ? CW + 1 : IDX_W + 1;

  entry_t mem [DEPTH];
  entry_t rd;

  logic [RW_W-1:0]   retire_width;
  logic [LAT_W-1:0]  mem_delay;
  logic [PW-1:0]     head;
  logic [CW-1:0]     count;
  logic [TIME_W-1:0] now;
  logic [CNT_W-1:0]  wakeups;
  logic [CNT_W-1:0]  wait_sum;
  logic [TIME_W-1:0] delta;
  logic [DW-1:0]     done;
  logic [STAT_W-1:0] res_status;
  logic [SLOT_W-1:0] res_slot;

  logic [1:0]        op_q;
  logic [TAG_W-1:0]  tag_q;
  logic [LAT_W-1:0]  lat_q;
  logic [IDX_W-1:0]  idx_q;

  logic [CW:0]       tail_sum;
  logic [PW-1:0]     tail;
  logic [PW-1:0]     head_next;
  logic [PW-1:0]     idx_mem;
  logic [4:0]        eff_w;
  logic              mem_we;
  logic              mem_re;
  logic [PW-1:0]     mem_waddr;
  logic [PW-1:0]     mem_raddr;
  entry_t            mem_wdata;

  always_comb begin
    tail_sum  = (CW+1)'(head) + (CW+1)'(count);
    tail      = (tail_sum >= (CW+1)'(DEPTH)) ? PW'(tail_sum - (CW+1)'(DEPTH)) : PW'(tail_sum);
    head_next = (head == PW'(DEPTH - 1)) ? '0 : head + PW'(1);
    idx_mem   = PW'(idx_q);
    eff_w     = (5'(retire_width) > 5'(MAX_WIDTH)) ? 5'(MAX_WIDTH) : 5'(retire_width);
  end

  always_comb begin
    mem_we    = cmd.ins | cmd.rearm | cmd.wake_wr;
    mem_re    = cmd.wake_rd | cmd.head_rd;
    mem_raddr = cmd.wake_rd ? idx_mem : head;
    mem_waddr = cmd.ins ? tail : idx_mem;
    mem_wdata.birth = now;
    mem_wdata.ready = now + TIME_W'(lat_q);
    mem_wdata.tag   = tag_q;
    if (cmd.rearm) begin
      mem_wdata.ready = now + TIME_W'(mem_delay);
    end else if (cmd.wake_wr) begin
      mem_wdata.birth = rd.birth;
      mem_wdata.ready = now;
      mem_wdata.tag   = rd.tag;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd <= mem[mem_raddr];
    end
  end

  always_comb begin
    sts.op         = op_t'(op_q);
    sts.full       = (count == CW'(DEPTH));
    sts.idx_ok     = (XW'(idx_q) < XW'(DEPTH));
    sts.can_retire = (5'(done) < eff_w) && (count != '0);
    sts.head_ready = (rd.ready <= now);
    sts.tag_match  = (rd.tag == tag_q);
    sts.out_free   = !rsp.valid || rsp.ready;
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      retire_width <= RETIRE_WIDTH_RST;
      mem_delay    <= MEM_DELAY_RST;
    end else if (cfg.valid) begin
      if (cfg.addr == REG_RETIRE_WIDTH) begin
        retire_width <= cfg.data[RW_W-1:0];
      end else if (cfg.addr == REG_MEM_DELAY) begin
        mem_delay <= cfg.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      now      <= '0;
      wakeups  <= '0;
      wait_sum <= '0;
    end else begin
      if (cmd.now_inc) begin
        now <= now + TIME_W'(1);
      end
      if (cmd.ins) begin
        count <= count + CW'(1);
      end
      if (cmd.retire) begin
        head  <= head_next;
        count <= count - CW'(1);
      end
      if (cmd.wake_wr) begin
        wakeups <= wakeups + CNT_W'(1);
      end
      if (cmd.wake_acc) begin
        wait_sum <= wait_sum + delta;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= '0;
    end else if (cmd.load) begin
      done <= '0;
    end else if (cmd.retire) begin
      done <= done + DW'(1);
    end
    if (cmd.load) begin
      op_q       <= opcode;
      tag_q      <= inst_tag;
      lat_q      <= latency;
      idx_q      <= entry_index;
      res_status <= ST_OK;
      res_slot   <= '0;
    end
    if (cmd.ins) begin
      res_slot <= SLOT_W'(tail);
    end
    if (cmd.set_full) begin
      res_status <= ST_FULL;
    end
    if (cmd.set_zombie) begin
      res_status <= ST_ZOMBIE;
    end
    if (cmd.take_delta) begin
      delta <= rd.ready - rd.birth;
    end
    if (cmd.wake_wr) begin
      delta <= now - rd.birth;
    end
    if (cmd.retire) begin
      if (delta >= TIME_W'(mem_delay)) begin
        res_status <= ST_LOST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.status         <= res_status;
      rsp.slot           <= res_slot;
      rsp.retired        <= RET_W'(done);
      rsp.occupancy      <= OCC_W'(count);
      rsp.wake_count     <= wakeups;
      rsp.wake_delay_sum <= wait_sum;
    end
  end

  `TRB_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(DEPTH), "occupancy above depth")
  `TRB_ASSERT_NOW(a_retire_nonempty, cmd.retire, count != '0, "retire from empty buffer")
  `TRB_ASSERT_NOW(a_done_bound, 1'b1, 5'(done) <= 5'(MAX_WIDTH), "too many retired in one tick")
  `TRB_ASSERT_NEXT(a_insert_grows, cmd.ins, count == $past(count) + CW'(1), "insert lost")

endmodule

// ===== src/timestamp_reorder_buffer.sv =====
// Top level of the timestamp reorder buffer: controller and datapath
//
//   channel  dir  payload                                          beat when
//   req      in   opcode, inst_tag, latency, entry_index           valid & ready
//   rsp      out  status, slot, retired, occupancy, wake_count,    valid & ready
//                 wake_delay_sum
//   cfg      in   addr, data (0 retire_width, 1 mem_delay)         valid & ready
//
// One item at a time. Insert and rearm act in S_EXEC; wakeup marks a slot out
// of range zombie, else reads it and marks a tag mismatch or writes it back.
// Tick advances the clock, then retires ready head entries up to the retire width;
// each retire is a registered read of the head entry, a compare and an update.
// rsp is a registered output; a new beat is taken while a result still waits,
// and the next result stalls in its final cycle until rsp drains.
// rst is synchronous; the entry memory is not cleared, cfg is always ready.
`timescale 1ns / 1ps
module timestamp_reorder_buffer #(
  parameter int DEPTH     = trb_pkg::DEPTH_DEF,
  parameter int MAX_WIDTH = trb_pkg::MAX_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  trb_in_if.sink    req,
  trb_out_if.source rsp,
  trb_cfg_if.sink   cfg
);
  import trb_pkg::*;

  trb_cmd_t cmd;
  trb_sts_t sts;
  logic     req_ready;

  assign req.ready = req_ready;

  trb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  trb_dpath #(
    .DEPTH     (DEPTH),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .opcode      (req.opcode),
    .inst_tag    (req.inst_tag),
    .latency     (req.latency),
    .entry_index (req.entry_index),
    .rsp         (rsp),
    .cfg         (cfg)
  );

endmodule
